### rtl/roman_numeral_encoder_macros.svh
// Assertion macros for the Roman numeral encoder.
`ifndef ROMAN_NUMERAL_ENCODER_MACROS_SVH
`define ROMAN_NUMERAL_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
`define RNE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rne check failed");
`define RNE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rne check failed");
`else
`define RNE_ASSERT_SAME(label, clk, rst, ante, cons)
`define RNE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/rne_pkg.sv
// Shared types, constants and digit tables for the Roman numeral encoder.
package rne_pkg;

   localparam logic [13:0] MAX_VALUE = 14'd3999;

   // reciprocal constants for division by ten at each stage
   localparam logic [15:0] RECIP_TEN_A = 16'd52429;  // >> 19, exact below 43690
   localparam logic [7:0]  RECIP_TEN_B = 8'd205;     // >> 11, exact below 1029
   localparam logic [3:0]  RECIP_TEN_C = 4'd13;      // >> 7, exact below 69

   localparam logic [6:0] CHAR_I = 7'h49;
   localparam logic [6:0] CHAR_V = 7'h56;
   localparam logic [6:0] CHAR_X = 7'h58;
   localparam logic [6:0] CHAR_L = 7'h4C;
   localparam logic [6:0] CHAR_C = 7'h43;
   localparam logic [6:0] CHAR_D = 7'h44;
   localparam logic [6:0] CHAR_M = 7'h4D;
   localparam logic [6:0] CHAR_NONE = 7'h00;

   // symbol codes within a decade
   localparam logic [1:0] SYM_ONE  = 2'd0;
   localparam logic [1:0] SYM_FIVE = 2'd1;
   localparam logic [1:0] SYM_TEN  = 2'd2;

   typedef struct packed {
      logic            err;
      logic [3:0][3:0] digit;   // digit[3] is thousands
   } entry_type;

   function automatic logic [2:0] digit_len(input logic [3:0] d);
      logic [2:0] len;
      case (d) inside
         4'd1, 4'd5:         len = 3'd1;
         4'd2, 4'd4, 4'd6,
         4'd9:               len = 3'd2;
         4'd3, 4'd7:         len = 3'd3;
         4'd8:               len = 3'd4;
         default:            len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [1:0] digit_sym(input logic [3:0] d, input logic [1:0] pos);
      logic [1:0] sym;
      case (d) inside
         4'd4:               sym = (pos == 2'd0) ? SYM_ONE : SYM_FIVE;
         [4'd5:4'd8]:        sym = (pos == 2'd0) ? SYM_FIVE : SYM_ONE;
         4'd9:               sym = (pos == 2'd0) ? SYM_ONE : SYM_TEN;
         default:            sym = SYM_ONE;
      endcase
      return sym;
   endfunction

   function automatic logic [6:0] roman_letter(input logic [1:0] dec, input logic [1:0] sym);
      logic [3:0] idx;
      logic [6:0] ch;
      idx = {1'b0, dec, 1'b0} + {2'b00, sym};
      case (idx)
         4'd0:    ch = CHAR_I;
         4'd1:    ch = CHAR_V;
         4'd2:    ch = CHAR_X;
         4'd3:    ch = CHAR_L;
         4'd4:    ch = CHAR_C;
         4'd5:    ch = CHAR_D;
         default: ch = CHAR_M;
      endcase
      return ch;
   endfunction

endpackage

### rtl/rne_front.sv
// Front end: accepts numbers, range checks them and splits them into decimal digits.
module rne_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [13:0]           req_number,
   output logic                  push_valid,
   input  logic                  push_ready,
   output rne_pkg::entry_type    push_data
);

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_err_ff;
   logic [8:0]  s1_q_ff;
   logic [3:0]  s1_d0_ff;

   logic        s2_valid_ff, s2_valid_in;
   logic        s2_err_ff;
   logic [5:0]  s2_q_ff;
   logic [3:0]  s2_d0_ff;
   logic [3:0]  s2_d1_ff;

   logic [11:0] n12;
   logic [27:0] prod_a;
   logic [8:0]  q_a;
   logic [3:0]  d0;
   logic        err;
   logic [16:0] prod_b;
   logic [5:0]  q_b;
   logic [3:0]  d1;
   logic [8:0]  prod_c;
   logic [1:0]  d3;
   logic [3:0]  d2;
   logic        s2_free;
   logic        s1_move;

   // stage 1: range check, units digit
   assign n12    = req_number[11:0];
   assign prod_a = 28'(n12) * 28'(rne_pkg::RECIP_TEN_A);
   assign q_a    = prod_a[27:19];
   assign d0     = 4'(n12 - {q_a, 3'b000} - 12'({q_a, 1'b0}));
   assign err    = (req_number == 14'd0) || (req_number > rne_pkg::MAX_VALUE);

   // stage 2: tens digit
   assign prod_b = 17'(s1_q_ff) * 17'(rne_pkg::RECIP_TEN_B);
   assign q_b    = prod_b[16:11];
   assign d1     = 4'(s1_q_ff - {q_b, 3'b000} - 9'({q_b, 1'b0}));

   // output of stage 2: hundreds and thousands
   assign prod_c = 9'(s2_q_ff) * 9'(rne_pkg::RECIP_TEN_C);
   assign d3     = prod_c[8:7];
   assign d2     = 4'(s2_q_ff - 6'({d3, 3'b000}) - 6'({d3, 1'b0}));

   assign s2_free   = !s2_valid_ff || push_ready;
   assign s1_move   = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s2_free;

   assign push_valid          = s2_valid_ff;
   assign push_data.err       = s2_err_ff;
   assign push_data.digit[3]  = {2'b00, d3};
   assign push_data.digit[2]  = d2;
   assign push_data.digit[1]  = s2_d1_ff;
   assign push_data.digit[0]  = s2_d0_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
      end
      s2_valid_in = s2_valid_ff;
      if (s2_free) begin
         s2_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_err_ff <= err;
         s1_q_ff   <= q_a;
         s1_d0_ff  <= d0;
      end
      if (s1_move) begin
         s2_err_ff <= s1_err_ff;
         s2_q_ff   <= q_b;
         s2_d0_ff  <= s1_d0_ff;
         s2_d1_ff  <= d1;
      end
   end

endmodule

### rtl/rne_fifo.sv
// Small queue of digit words between the front end and the letter sequencer.
module rne_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  rne_pkg::entry_type    push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output rne_pkg::entry_type    pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   rne_pkg::entry_type mem [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/rne_back.sv
// Back end: walks a word's digits, one Roman letter per cycle unless stalled.
module rne_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  rne_pkg::entry_type    pop_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [6:0]            rsp_letter,
   output logic                  rsp_last,
   output logic                  rsp_out_of_range
);

   logic               cur_valid_ff, cur_valid_in;
   rne_pkg::entry_type cur_ff;
   logic [1:0]         dec_ff, dec_in;
   logic [1:0]         pos_ff, pos_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [6:0]         rsp_letter_ff;
   logic               rsp_last_ff;
   logic               rsp_oor_ff;

   logic [3:0]         d;
   logic [2:0]         len;
   logic [1:0]         sym;
   logic               lower_any;
   logic [1:0]         next_dec;
   logic [1:0]         first_dec;
   logic               end_of_digit;
   logic               is_last;
   logic [6:0]         letter;
   logic               ld_ok;
   logic               emit;
   logic               pop;

   assign d            = cur_ff.digit[dec_ff];
   assign len          = rne_pkg::digit_len(d);
   assign sym          = rne_pkg::digit_sym(d, pos_ff);
   assign end_of_digit = ({1'b0, pos_ff} == (len - 3'd1));
   assign is_last      = cur_ff.err || (end_of_digit && !lower_any);
   assign letter       = cur_ff.err ? rne_pkg::CHAR_NONE : rne_pkg::roman_letter(dec_ff, sym);

   assign ld_ok     = !rsp_valid_ff || rsp_ready;
   assign emit      = cur_valid_ff && ld_ok;
   assign pop_ready = !cur_valid_ff || (emit && is_last);
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      lower_any = 1'b0;
      next_dec  = 2'd0;
      first_dec = 2'd0;
      for (int k = 0; k < 4; k++) begin
         if ((2'(k) < dec_ff) && (cur_ff.digit[k] != 4'd0)) begin
            lower_any = 1'b1;
            next_dec  = 2'(k);
         end
         if (pop_data.digit[k] != 4'd0) begin
            first_dec = 2'(k);
         end
      end
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      dec_in       = dec_ff;
      pos_in       = pos_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         dec_in       = first_dec;
         pos_in       = 2'd0;
      end else if (emit) begin
         if (is_last) begin
            cur_valid_in = 1'b0;
         end else if (end_of_digit) begin
            dec_in = next_dec;
            pos_in = 2'd0;
         end else begin
            pos_in = pos_ff + 2'd1;
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dec_ff       <= 2'd0;
         pos_ff       <= 2'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         dec_ff       <= dec_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= pop_data;
      end
      if (emit) begin
         rsp_letter_ff <= letter;
         rsp_last_ff   <= is_last;
         rsp_oor_ff    <= cur_ff.err;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_letter       = rsp_letter_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

### rtl/roman_numeral_encoder.sv
// Top level of the Roman numeral encoder: front end, digit queue and letter sequencer.
//
// Usage:
//   req channel: one 14-bit binary number per word (req_valid / req_ready).
//   rsp channel: one ASCII Roman letter per word, most significant first,
//   rsp_last set on the final letter of each number. A number of 0 or above
//   3999 gives a single word with letter 0, rsp_last and rsp_out_of_range set.
//   Path: the number passes the two digit-split stages, a queue slot, the
//   sequencer's word register and the output register before its first letter shows.
//   Throughput: one letter per cycle while rsp_ready is high; a number
//   occupies the letter sequencer until its last letter is sent, 1 to 15
//   letters (3888 is the longest). Numbers are taken one per cycle until the
//   FIFO_DEPTH-entry digit queue and the two front stages are full.
//   Reset clears the pipeline, the queue and the output register; no
//   letter is pending afterward.
//   When the receiver holds rsp_ready low, the current letter holds on the
//   rsp ports and the sequencer waits; the front keeps taking numbers until
//   the queue and the two front stages fill, then drops req_ready.
`include "roman_numeral_encoder_macros.svh"

module roman_numeral_encoder #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [13:0] req_number,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_letter,
   output logic        rsp_last,
   output logic        rsp_out_of_range
);

   logic               push_valid;
   logic               push_ready;
   rne_pkg::entry_type push_data;
   logic               pop_valid;
   logic               pop_ready;
   rne_pkg::entry_type pop_data;

   logic               err_word_ok;
   logic               letter_ok;
   logic [8:0]         rsp_word;

   rne_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_number (req_number),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   rne_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rne_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_data         (pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_letter       (rsp_letter),
      .rsp_last         (rsp_last),
      .rsp_out_of_range (rsp_out_of_range)
   );

   assign err_word_ok = rsp_last && (rsp_letter == rne_pkg::CHAR_NONE);
   assign letter_ok   = (rsp_letter == rne_pkg::CHAR_I) || (rsp_letter == rne_pkg::CHAR_V) ||
                        (rsp_letter == rne_pkg::CHAR_X) || (rsp_letter == rne_pkg::CHAR_L) ||
                        (rsp_letter == rne_pkg::CHAR_C) || (rsp_letter == rne_pkg::CHAR_D) ||
                        (rsp_letter == rne_pkg::CHAR_M);
   assign rsp_word    = {rsp_letter, rsp_last, rsp_out_of_range};

   `RNE_ASSERT_SAME(a_err_word, clock, reset, rsp_valid && rsp_out_of_range, err_word_ok)
   `RNE_ASSERT_SAME(a_letter_set, clock, reset, rsp_valid && !rsp_out_of_range, letter_ok)
   `RNE_ASSERT_NEXT(a_run_unbroken, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid)
   `RNE_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

endmodule

### verif/roman_numeral_encoder_checker.sv
// Checker for the Roman numeral encoder: predicts each letter run and compares rsp words.
`timescale 1ns / 100ps

module roman_numeral_encoder_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [13:0] req_number,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [6:0]  rsp_letter,
   input  logic        rsp_last,
   input  logic        rsp_out_of_range,
   output int          fail_count,
   output int          words_pending
);

   typedef struct packed {
      logic [6:0] letter;
      logic       last;
      logic       out_of_range;
   } roman_word_type;

   localparam logic [6:0] ROMAN_CHARS [7] = '{rne_pkg::CHAR_I, rne_pkg::CHAR_V,
                                              rne_pkg::CHAR_X, rne_pkg::CHAR_L,
                                              rne_pkg::CHAR_C, rne_pkg::CHAR_D,
                                              rne_pkg::CHAR_M};

   roman_word_type letters_due[$];

   function automatic void push_letter(input int dec, input int sym);
      int idx;
      roman_word_type w;
      idx = 2 * dec + sym;
      if (idx > 6) begin
         idx = 6;
      end
      w.letter = ROMAN_CHARS[idx];
      w.last = 1'b0;
      w.out_of_range = 1'b0;
      letters_due.push_back(w);
   endfunction

   function automatic void queue_numeral(input logic [13:0] n);
      int value;
      int d;
      int dec;
      int k;
      int digits [4];
      roman_word_type w;
      if (n == 14'd0 || n > rne_pkg::MAX_VALUE) begin
         w.letter = rne_pkg::CHAR_NONE;
         w.last = 1'b1;
         w.out_of_range = 1'b1;
         letters_due.push_back(w);
         return;
      end
      value = n;
      for (dec = 0; dec < 4; dec++) begin
         digits[dec] = value % 10;
         value = value / 10;
      end
      for (dec = 3; dec >= 0; dec--) begin
         d = digits[dec];
         case (d)
            4: begin
               push_letter(dec, rne_pkg::SYM_ONE);
               push_letter(dec, rne_pkg::SYM_FIVE);
            end
            9: begin
               push_letter(dec, rne_pkg::SYM_ONE);
               push_letter(dec, rne_pkg::SYM_TEN);
            end
            default: begin
               if (d >= 5) begin
                  push_letter(dec, rne_pkg::SYM_FIVE);
               end
               for (k = 0; k < d % 5; k++) begin
                  push_letter(dec, rne_pkg::SYM_ONE);
               end
            end
         endcase
      end
      w = letters_due.pop_back();
      w.last = 1'b1;
      letters_due.push_back(w);
   endfunction

   function automatic void check_field(input string field, input logic [6:0] want,
                                       input logic [6:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      roman_word_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (letters_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected word, expected none, got letter %0h last %0b err %0b",
                        $time, rsp_letter, rsp_last, rsp_out_of_range);
            end else begin
               want = letters_due.pop_front();
               check_field("letter", want.letter, rsp_letter);
               check_field("last", {6'd0, want.last}, {6'd0, rsp_last});
               check_field("out_of_range", {6'd0, want.out_of_range},
                           {6'd0, rsp_out_of_range});
            end
         end
         if (req_valid && req_ready) begin
            queue_numeral(req_number);
         end
      end
      words_pending = letters_due.size();
   end

endmodule

### verif/roman_numeral_encoder_tb.sv
// Testbench top for the Roman numeral encoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module roman_numeral_encoder_tb;

   localparam logic [13:0] DIRECTED [25] = '{
      14'd1, 14'd2, 14'd3, 14'd4, 14'd5, 14'd6, 14'd7, 14'd8, 14'd9, 14'd14,
      14'd40, 14'd49, 14'd90, 14'd400, 14'd444, 14'd900, 14'd1000, 14'd1994,
      14'd3888, 14'd3999, 14'd4000, 14'd0, 14'd16383, 14'd8192, 14'd2421
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [13:0] req_number;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [6:0]  rsp_letter;
   logic        rsp_last;
   logic        rsp_out_of_range;

   int fail_count;
   int words_pending;
   int send_idle_pct;
   int recv_idle_pct;
   bit long_hold;

   roman_numeral_encoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_number       (req_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_letter       (rsp_letter),
      .rsp_last         (rsp_last),
      .rsp_out_of_range (rsp_out_of_range)
   );

   roman_numeral_encoder_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_number       (req_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_letter       (rsp_letter),
      .rsp_last         (rsp_last),
      .rsp_out_of_range (rsp_out_of_range),
      .fail_count       (fail_count),
      .words_pending    (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("TB_ERROR");
      $finish;
   end

   // rsp side: random stall bursts, plus one long hold-off to back up the queue
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
            long_hold = 1'b0;
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 399) < recv_idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_number(input logic [13:0] n);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         gap = $urandom_range(1, 15);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_number <= n;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      int i;
      int mode;
      logic [13:0] n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_number = 14'd0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      long_hold = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 25;
      recv_idle_pct = 25;
      for (i = 0; i < 25; i++) begin
         send_number(DIRECTED[i]);
      end

      for (i = 0; i < 235; i++) begin
         if (i % 40 == 0) begin
            mode = $urandom_range(0, 2);
            send_idle_pct = (mode == 0) ? 0 : (mode == 1) ? 20 : 60;
            mode = $urandom_range(0, 2);
            recv_idle_pct = (mode == 0) ? 0 : (mode == 1) ? 20 : 60;
         end
         if (i >= 195) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (i == 100) begin
            long_hold = 1'b1;
         end
         mode = $urandom_range(0, 19);
         if (mode < 16) begin
            // digit by digit so every digit pattern in every decade shows up
            n = 14'($urandom_range(0, 3) * 1000 + $urandom_range(0, 9) * 100
                    + $urandom_range(0, 9) * 10 + $urandom_range(0, 9));
         end else if (mode == 16) begin
            n = 14'($urandom_range(3990, 4010));
         end else if (mode == 17) begin
            n = 14'($urandom_range(4000, 16383));
         end else begin
            n = 14'($urandom_range(0, 16383));
         end
         send_number(n);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (words_pending != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
